// File: sv/wcjq_pkg.sv
// ----------------------------------------------------------------------------
// Work-credit job queue package
// Shared sizes, command codes, the controller state type and the per-cell
// control word.
// ----------------------------------------------------------------------------
`default_nettype none

package wcjq_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned WORK_BITS   = 24;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = 3;

  typedef enum logic {
    FUNC_ADD,
    FUNC_ADVANCE
  } func_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  // Control word for one queue cell.
  typedef struct packed {
    logic shift;  // take the value of the cell behind
    logic load;   // write a new job
    logic sub;    // subtract the applied work
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/wcjq_cell.sv
// ----------------------------------------------------------------------------
// Work-credit job queue cell
// Holds the remaining work of one queued job; shifts toward the front on a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module wcjq_cell (
  input  wire                                 clk_i,
  input  wire wcjq_pkg::cell_ctrl_t           ctrl_i,
  input  wire logic [wcjq_pkg::WORK_BITS-1:0] load_data_i,
  input  wire logic [wcjq_pkg::WORK_BITS-1:0] next_data_i,
  input  wire logic [wcjq_pkg::WORK_BITS-1:0] sub_data_i,
  output logic      [wcjq_pkg::WORK_BITS-1:0] data_o
);

  logic [wcjq_pkg::WORK_BITS-1:0] work_q, work_d;

  always_comb begin
    work_d = work_q;
    if (ctrl_i.shift) begin
      work_d = next_data_i;
    end else if (ctrl_i.load) begin
      work_d = load_data_i;
    end else if (ctrl_i.sub) begin
      work_d = work_q - sub_data_i;
    end
  end

  // Payload only: an entry is read only after it was written.
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign data_o = work_q;

endmodule

`default_nettype wire

// File: sv/work_credit_job_queue_unit.sv
// ----------------------------------------------------------------------------
// Work-credit job queue
// Bounded queue of jobs with remaining work in unsigned Q16.8; adds push a job,
// advances burn work off the front, popping every job that finishes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An add's result strobes
// on done_o in the cycle after it is taken, and busy stays low, so a new item
// may follow at once. An advance that has work to do holds busy while it walks
// the front jobs it touches, the front cell subtracting or popping once per
// cycle, and its result strobes on done_o as busy falls; an advance with no
// work to do finishes like an add. Each result is on the ports for one cycle
// only and cannot be stalled. max_jobs is written through the cfg channel,
// which is always ready.
`default_nettype none

module work_credit_job_queue_unit (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start,
  output logic                                busy,
  input  wire logic                           func_i,
  input  wire logic [wcjq_pkg::WORK_BITS-1:0] amount_i,
  input  wire logic                           disabled_i,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [2:0]                     cfg_max_jobs_i,
  output logic                                done_o,
  output logic                                accepted_o,
  output logic      [2:0]                     completed_o,
  output logic      [2:0]                     occupancy_o,
  output logic                                front_busy_o
);

  localparam int unsigned Depth = wcjq_pkg::QUEUE_DEPTH;
  localparam int unsigned WorkW = wcjq_pkg::WORK_BITS;
  localparam int unsigned CntW  = wcjq_pkg::CNT_W;

  wcjq_pkg::state_e state_q, state_d;

  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  cmpl_q, cmpl_d;
  logic [WorkW-1:0] carry_q, carry_d;
  logic [2:0]       max_jobs_q;

  logic             res_valid_q, res_valid_d;
  logic             res_acc_q, res_acc_d;
  logic [CntW-1:0]  res_cmpl_q, res_cmpl_d;
  logic [CntW-1:0]  res_occ_q, res_occ_d;

  wcjq_pkg::cell_ctrl_t       cell_ctrl [Depth];
  logic [WorkW-1:0]           cell_data [Depth];

  logic             take_front;
  logic [WorkW-1:0] carry_left;
  logic             walk_finish;
  logic             add_ok;
  logic             walk_ok;
  logic             item_go;

  // Row of cells; cell 0 is the front of the queue.
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic [WorkW-1:0] next_data;
    if (g == Depth - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[g+1];
    end
    wcjq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[g]),
      .load_data_i (amount_i),
      .next_data_i (next_data),
      .sub_data_i  (carry_q),
      .data_o      (cell_data[g])
    );
  end

  assign item_go     = start && !busy;
  assign add_ok      = (amount_i != '0) && !disabled_i
                    && (count_q < CntW'(max_jobs_q)) && (count_q < CntW'(Depth));
  assign walk_ok     = (amount_i != '0) && !disabled_i && (count_q != '0);
  assign take_front  = (cell_data[0] <= carry_q);
  assign carry_left  = carry_q - cell_data[0];
  assign walk_finish = !take_front || (count_q == CntW'(1)) || (carry_left == '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wcjq_pkg::ST_IDLE: begin
        if (item_go && (func_i == wcjq_pkg::FUNC_ADVANCE) && walk_ok) begin
          state_d = wcjq_pkg::ST_WALK;
        end
      end
      wcjq_pkg::ST_WALK: begin
        if (walk_finish) begin
          state_d = wcjq_pkg::ST_IDLE;
        end
      end
      default: state_d = wcjq_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    busy        = 1'b0;
    count_d     = count_q;
    cmpl_d      = cmpl_q;
    carry_d     = carry_q;
    res_valid_d = 1'b0;
    res_acc_d   = res_acc_q;
    res_cmpl_d  = res_cmpl_q;
    res_occ_d   = res_occ_q;
    for (int i = 0; i < Depth; i++) begin
      cell_ctrl[i] = '0;
    end
    unique case (state_q)
      wcjq_pkg::ST_IDLE: begin
        if (item_go) begin
          if (func_i == wcjq_pkg::FUNC_ADD) begin
            res_valid_d = 1'b1;
            res_acc_d   = add_ok;
            res_cmpl_d  = '0;
            res_occ_d   = count_q;
            if (add_ok) begin
              cell_ctrl[count_q[wcjq_pkg::IDX_W-1:0]].load = 1'b1;
              count_d   = count_q + CntW'(1);
              res_occ_d = count_d;
            end
          end else if (walk_ok) begin
            carry_d = amount_i;
            cmpl_d  = '0;
          end else begin
            res_valid_d = 1'b1;
            res_acc_d   = 1'b0;
            res_cmpl_d  = '0;
            res_occ_d   = count_q;
          end
        end
      end
      wcjq_pkg::ST_WALK: begin
        busy = 1'b1;
        if (take_front) begin
          // Front job finishes: pop it and carry the leftover onward.
          for (int i = 0; i < Depth; i++) begin
            cell_ctrl[i].shift = 1'b1;
          end
          count_d = count_q - CntW'(1);
          cmpl_d  = cmpl_q + CntW'(1);
          carry_d = carry_left;
        end else begin
          cell_ctrl[0].sub = 1'b1;
          carry_d          = '0;
        end
        if (walk_finish) begin
          res_valid_d = 1'b1;
          res_acc_d   = 1'b0;
          res_cmpl_d  = cmpl_d;
          res_occ_d   = count_d;
        end
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wcjq_pkg::ST_IDLE;
      count_q     <= '0;
      max_jobs_q  <= 3'd4;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_jobs_q <= cfg_max_jobs_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmpl_q     <= cmpl_d;
    carry_q    <= carry_d;
    res_acc_q  <= res_acc_d;
    res_cmpl_q <= res_cmpl_d;
    res_occ_q  <= res_occ_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign done_o       = res_valid_q;
  assign accepted_o   = res_acc_q;
  assign completed_o  = res_cmpl_q;
  assign occupancy_o  = res_occ_q;
  assign front_busy_o = (res_occ_q != '0);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue occupancy exceeds depth");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (count_q != '0))
    else $error("walking an empty queue");

  a_occ_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (occupancy_o == count_q))
    else $error("reported occupancy differs from queue state");

  a_add_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && accepted_o) |-> (completed_o == '0))
    else $error("add result reports completions");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("walk ended without a result");

endmodule

`default_nettype wire

// File: dv/work_credit_job_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// Work-credit job queue testbench
// Drives add and advance commands through the start/busy port and predicts
// every result strobe from a queue model in the bench. Directed beats cover the
// corner cases, then random bursts run under several max_jobs settings.
// ----------------------------------------------------------------------------

module work_credit_job_queue_unit_tb;

  typedef struct packed {
    logic       accepted;
    logic [2:0] completed;
    logic [2:0] occupancy;
    logic       front_busy;
  } outcome_t;

  localparam logic [wcjq_pkg::WORK_BITS-1:0] WORK_MAX = {wcjq_pkg::WORK_BITS{1'b1}};

  // Tracks the queued jobs and the outcome each accepted beat must produce.
  class job_ledger;
    logic [wcjq_pkg::WORK_BITS-1:0] work_left [wcjq_pkg::QUEUE_DEPTH];
    int unsigned          head;
    int unsigned          count;
    int unsigned          max_jobs;
    outcome_t             awaited [$];
    int unsigned          failures;
    int unsigned          items;
    int unsigned          pushed;
    int unsigned          finished;
    int unsigned          refused;

    function new();
      foreach (work_left[i]) work_left[i] = '0;
      head     = 0;
      count    = 0;
      max_jobs = 4;
      failures = 0;
      items    = 0;
      pushed   = 0;
      finished = 0;
      refused  = 0;
    endfunction

    function void set_max_jobs(logic [2:0] value);
      max_jobs = 32'(value);
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Sum of the first k queued jobs, clipped to the work width.
    function logic [wcjq_pkg::WORK_BITS-1:0] front_total(int unsigned k);
      longint unsigned sum;
      sum = 0;
      for (int unsigned i = 0; i < k && i < count; i++)
        sum += work_left[(head + i) % wcjq_pkg::QUEUE_DEPTH];
      if (sum == 0 || sum > WORK_MAX) return WORK_MAX;
      return sum[wcjq_pkg::WORK_BITS-1:0];
    endfunction

    function void note_item(wcjq_pkg::func_e op, logic [wcjq_pkg::WORK_BITS-1:0] amount,
                            logic dis);
      outcome_t                       res;
      int unsigned                    limit;
      logic [wcjq_pkg::WORK_BITS-1:0] carry;
      res = '0;
      items++;
      if (op == wcjq_pkg::FUNC_ADD) begin
        limit = (max_jobs > wcjq_pkg::QUEUE_DEPTH) ? wcjq_pkg::QUEUE_DEPTH : max_jobs;
        if (amount != 0 && !dis && count < limit) begin
          work_left[(head + count) % wcjq_pkg::QUEUE_DEPTH] = amount;
          count++;
          pushed++;
          res.accepted = 1'b1;
        end else begin
          refused++;
        end
      end else if (!dis && count != 0 && amount != 0) begin
        carry = amount;
        // Each finished job hands its leftover to the next one in line.
        while (count != 0 && carry != 0) begin
          if (work_left[head] <= carry) begin
            carry -= work_left[head];
            head = (head + 1) % wcjq_pkg::QUEUE_DEPTH;
            count--;
            res.completed++;
            finished++;
          end else begin
            work_left[head] -= carry;
            carry = '0;
          end
        end
      end
      res.occupancy  = count[2:0];
      res.front_busy = (count != 0);
      awaited.push_back(res);
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (awaited.size() == 0) begin
        $error("result strobe with no item outstanding");
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        failures++;
      end
      if (got.completed !== want.completed) begin
        $error("completed: expected %0d, got %0d", want.completed, got.completed);
        failures++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
        failures++;
      end
      if (got.front_busy !== want.front_busy) begin
        $error("front_busy: expected %0d, got %0d", want.front_busy, got.front_busy);
        failures++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic                           func_i;
  logic [wcjq_pkg::WORK_BITS-1:0] amount_i;
  logic                           disabled_i;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [2:0]                     cfg_max_jobs_i;
  logic                           done_o;
  logic                           accepted_o;
  logic [2:0]                     completed_o;
  logic [2:0]                     occupancy_o;
  logic                           front_busy_o;

  job_ledger ledger;

  work_credit_job_queue_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .amount_i       (amount_i),
    .disabled_i     (disabled_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_max_jobs_i (cfg_max_jobs_i),
    .done_o         (done_o),
    .accepted_o     (accepted_o),
    .completed_o    (completed_o),
    .occupancy_o    (occupancy_o),
    .front_busy_o   (front_busy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Check the strobe first: a result always belongs to an earlier beat.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      ledger.check_result({accepted_o, completed_o, occupancy_o, front_busy_o});
    if (rst_ni && start && !busy)
      ledger.note_item(wcjq_pkg::func_e'(func_i), amount_i, disabled_i);
  end

  // Presents one command and returns at the falling edge after it is taken.
  task automatic send_item(wcjq_pkg::func_e op, logic [wcjq_pkg::WORK_BITS-1:0] amount,
                           logic dis);
    start      <= 1'b1;
    func_i     <= op;
    amount_i   <= amount;
    disabled_i <= dis;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic pause(int unsigned cycles);
    start      <= 1'b0;
    func_i     <= 1'($urandom_range(1));
    amount_i   <= wcjq_pkg::WORK_BITS'($urandom);
    disabled_i <= 1'($urandom_range(1));
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_max_jobs(logic [2:0] value);
    drain();
    repeat (4) @(negedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_max_jobs_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.set_max_jobs(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    wcjq_pkg::func_e                op;
    logic [wcjq_pkg::WORK_BITS-1:0] amount;
    logic                           dis;
    int unsigned                    limit;
    int unsigned                    pick;
    limit = (ledger.max_jobs > wcjq_pkg::QUEUE_DEPTH) ? wcjq_pkg::QUEUE_DEPTH
                                                      : ledger.max_jobs;
    // Lean toward adds when the queue is empty and toward advances when it is full.
    if (ledger.count == 0)
      op = ($urandom_range(9) < 7) ? wcjq_pkg::FUNC_ADD : wcjq_pkg::FUNC_ADVANCE;
    else if (ledger.count >= limit)
      op = ($urandom_range(9) < 3) ? wcjq_pkg::FUNC_ADD : wcjq_pkg::FUNC_ADVANCE;
    else
      op = ($urandom_range(9) < 5) ? wcjq_pkg::FUNC_ADD : wcjq_pkg::FUNC_ADVANCE;
    dis  = ($urandom_range(15) == 0);
    pick = $urandom_range(99);
    if (pick < 3)
      amount = '0;
    else if (pick < 7)
      amount = WORK_MAX;
    else if (pick < 11)
      amount = wcjq_pkg::WORK_BITS'(1);
    else if (pick < 24)
      amount = wcjq_pkg::WORK_BITS'($urandom);
    else if (op == wcjq_pkg::FUNC_ADVANCE && pick < 50)
      amount = ledger.front_total($urandom_range(1, wcjq_pkg::QUEUE_DEPTH));
    else
      amount = wcjq_pkg::WORK_BITS'($urandom_range(1, 'h400));
    send_item(op, amount, dis);
  endtask

  task automatic run_phase(int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    bit          drained;
    sent    = 0;
    drained = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        random_item();
        sent++;
      end
      if (!drained && sent >= n_items / 2) begin
        drain();
        drained = 1;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) pause(gap);
    end
  endtask

  initial begin
    logic [2:0] settings [8];
    settings = '{3'd0, 3'd1, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};
    ledger         = new();
    rst_ni         = 1'b0;
    start          = 1'b0;
    func_i         = 1'b0;
    amount_i       = '0;
    disabled_i     = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_max_jobs_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed beats at the reset setting of four jobs.
    send_item(wcjq_pkg::FUNC_ADVANCE, 24'h000005, 1'b0);  // empty queue
    send_item(wcjq_pkg::FUNC_ADD,     24'h000000, 1'b0);  // zero job refused
    send_item(wcjq_pkg::FUNC_ADD,     WORK_MAX,   1'b0);
    send_item(wcjq_pkg::FUNC_ADD,     24'h000001, 1'b0);
    send_item(wcjq_pkg::FUNC_ADD,     24'h000040, 1'b1);  // disabled add refused
    send_item(wcjq_pkg::FUNC_ADD,     24'h000100, 1'b0);
    send_item(wcjq_pkg::FUNC_ADD,     24'h000080, 1'b0);  // now full
    send_item(wcjq_pkg::FUNC_ADD,     24'h000007, 1'b0);  // refused, full
    send_item(wcjq_pkg::FUNC_ADVANCE, 24'h000000, 1'b0);  // zero work does nothing
    send_item(wcjq_pkg::FUNC_ADVANCE, WORK_MAX,   1'b1);  // disabled advance does nothing
    send_item(wcjq_pkg::FUNC_ADVANCE, WORK_MAX,   1'b0);  // exact finish of the front job
    send_item(wcjq_pkg::FUNC_ADVANCE, 24'h000001, 1'b0);  // exact finish again
    send_item(wcjq_pkg::FUNC_ADVANCE, 24'h000180, 1'b0);  // two jobs, carry ends at zero
    send_item(wcjq_pkg::FUNC_ADD,     24'h000001, 1'b0);
    send_item(wcjq_pkg::FUNC_ADD,     24'h000001, 1'b0);
    send_item(wcjq_pkg::FUNC_ADD,     24'h000001, 1'b0);
    send_item(wcjq_pkg::FUNC_ADD,     24'h000001, 1'b0);
    send_item(wcjq_pkg::FUNC_ADVANCE, WORK_MAX,   1'b0);  // pops every job, queue empties
    send_item(wcjq_pkg::FUNC_ADD,     24'h000300, 1'b0);
    send_item(wcjq_pkg::FUNC_ADD,     24'h7FFFFF, 1'b0);
    send_item(wcjq_pkg::FUNC_ADVANCE, 24'h000100, 1'b0);  // partial work on the front
    send_item(wcjq_pkg::FUNC_ADVANCE, 24'h800000, 1'b0);  // finishes one, carry into next
    send_item(wcjq_pkg::FUNC_ADVANCE, 24'h7FFFFF, 1'b0);
    pause(3);

    foreach (settings[i]) begin
      write_max_jobs(settings[i]);
      run_phase(110);
    end

    drain();
    repeat (10) @(negedge clk_i);
    if (ledger.pending() != 0) begin
      $error("%0d results never arrived", ledger.pending());
      ledger.failures++;
    end
    $display("Ran %0d commands over max_jobs settings 0 to 7, in bursts and gaps.",
             ledger.items);
    $display("Jobs pushed %0d, completed %0d, adds refused %0d, mismatches %0d.",
             ledger.pushed, ledger.finished, ledger.refused, ledger.failures);
    if (ledger.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("Run timed out with %0d results outstanding.", ledger.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule
